### hdl/xs128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xs128_pkg;

    localparam logic [31:0] INIT_Y = 32'd842502087;
    localparam logic [31:0] INIT_Z = 32'd3579807591;
    localparam logic [31:0] INIT_W = 32'd273326509;
    localparam logic [30:0] MASK31 = 31'h7FFF_FFFF;
    localparam logic [5:0]  BITS_EMPTY = 6'd32;

    typedef enum logic [2:0] {
        OP_RAW    = 3'd0,
        OP_MASKED = 3'd1,
        OP_UPPER  = 3'd2,
        OP_RANGE  = 3'd3,
        OP_BOOL   = 3'd4
    } t_op;

    typedef enum logic {
        K_DIRECT = 1'b0,
        K_SCALE  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [32:0]        direct;
        logic [30:0]        frac;
        logic signed [31:0] lo;
        logic signed [32:0] span;
    } t_mid;

endpackage
`default_nettype wire

### hdl/xorshift128_random_source.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted request's word passes the middle queue, stage-one register and output queue.
// One request per cycle while full is low; the xorshift step is combinational.
// The scaling multiply has one pipeline register; the truncating add has none.
// Reset (synchronous, active low): seed 0, state words at their constants,
// bit buffer empty, both queues empty.
module xorshift128_random_source #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic        [2:0]  i_opcode,
    input  wire logic signed [31:0] i_lower_bound,
    input  wire logic signed [31:0] i_upper_bound,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [32:0]      o_value
);
    localparam int MW = $bits(xs128_pkg::t_mid);

    logic                               w_mid_wr, w_mid_rd, w_mid_empty, w_mid_full;
    xs128_pkg::t_mid                    w_mid_in, w_mid_out;
    logic [MW-1:0]                      w_mid_bits;
    logic [$clog2(MID_DEPTH+1)-1:0]     w_mid_count;
    logic                               w_out_wr, w_out_full;
    logic [32:0]                        w_out_in, w_out_bits;
    logic [$clog2(OUT_DEPTH+1)-1:0]     w_out_count;

    assign o_cfg_ready = 1'b1;

    // hold the input while a seed word is written or the middle queue is full
    assign full = w_mid_full || i_cfg_valid;

    xs128_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_opcode      (i_opcode),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_wr_en       (w_mid_wr),
        .o_entry       (w_mid_in)
    );

    xs128_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_mid_wr),
        .i_wr_data (w_mid_in),
        .i_rd_en   (w_mid_rd),
        .o_rd_data (w_mid_bits),
        .o_empty   (w_mid_empty),
        .o_full    (w_mid_full),
        .o_count   (w_mid_count)
    );

    assign w_mid_out = xs128_pkg::t_mid'(w_mid_bits);

    xs128_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid       (w_mid_out),
        .o_mid_rd    (w_mid_rd),
        .i_out_count (w_out_count),
        .o_out_wr    (w_out_wr),
        .o_out_value (w_out_in)
    );

    xs128_fifo #(.WIDTH(33), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_out_wr),
        .i_wr_data (w_out_in),
        .i_rd_en   (pop),
        .o_rd_data (w_out_bits),
        .o_empty   (empty),
        .o_full    (w_out_full),
        .o_count   (w_out_count)
    );

    assign o_value = $signed(w_out_bits);

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_wr |-> !w_out_full)
        else $error("output queue written while full");
    a_mid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
        else $error("middle queue count out of range");

endmodule
`default_nettype wire

### hdl/xs128_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module xs128_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [WIDTH-1:0]           i_wr_data,
    input  wire logic                       i_rd_en,
    output logic      [WIDTH-1:0]           o_rd_data,
    output logic                            o_empty,
    output logic                            o_full,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_wr, w_rd;

    assign w_wr = i_wr_en && !o_full;
    assign w_rd = i_rd_en && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;

endmodule
`default_nettype wire

### hdl/xs128_front.sv
`timescale 1ns / 1ps
`default_nettype none
module xs128_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic        [2:0]  i_opcode,
    input  wire logic signed [31:0] i_lower_bound,
    input  wire logic signed [31:0] i_upper_bound,
    output logic                    o_wr_en,
    output xs128_pkg::t_mid         o_entry
);
    logic [31:0] r_x, n_x, r_y, n_y, r_z, n_z, r_w, n_w;
    logic [31:0] r_buf, n_buf;
    logic [5:0]  r_bits, n_bits;
    logic [31:0] w_t, w_new;
    logic        w_acc;

    assign w_acc = i_push && !i_full;
    assign w_t   = r_x ^ (r_x << 11);
    assign w_new = r_w ^ (r_w >> 19) ^ w_t ^ (w_t >> 8);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_w = r_w;
        n_buf = r_buf;
        n_bits = r_bits;
        o_entry.kind   = xs128_pkg::K_DIRECT;
        o_entry.direct = '0;
        o_entry.frac   = w_new[30:0] & xs128_pkg::MASK31;
        o_entry.lo     = '0;
        o_entry.span   = '0;
        if (i_cfg_valid) begin
            n_x = i_cfg_data;
            n_y = xs128_pkg::INIT_Y;
            n_z = xs128_pkg::INIT_Z;
            n_w = xs128_pkg::INIT_W;
            n_buf = '0;
            n_bits = xs128_pkg::BITS_EMPTY;
        end else if (w_acc) begin
            case (i_opcode) inside
                xs128_pkg::OP_RAW, xs128_pkg::OP_MASKED,
                xs128_pkg::OP_UPPER, xs128_pkg::OP_RANGE: begin
                    n_x = r_y;
                    n_y = r_z;
                    n_z = r_w;
                    n_w = w_new;
                end
                xs128_pkg::OP_BOOL: begin
                    if (r_bits >= xs128_pkg::BITS_EMPTY) begin
                        n_x = r_y;
                        n_y = r_z;
                        n_z = r_w;
                        n_w = w_new;
                        n_buf = w_new;
                        n_bits = 6'd1;
                    end else begin
                        n_buf = r_buf >> 1;
                        n_bits = r_bits + 6'd1;
                    end
                end
                default: begin
                end
            endcase
        end
        unique case (i_opcode)
            xs128_pkg::OP_RAW:    o_entry.direct = {1'b0, w_new};
            xs128_pkg::OP_MASKED: o_entry.direct = {2'b00, w_new[30:0]};
            xs128_pkg::OP_UPPER: begin
                o_entry.kind = xs128_pkg::K_SCALE;
                o_entry.span = 33'(i_upper_bound);
            end
            xs128_pkg::OP_RANGE: begin
                o_entry.kind = xs128_pkg::K_SCALE;
                o_entry.lo   = i_lower_bound;
                o_entry.span = 33'(i_upper_bound) - 33'(i_lower_bound);
            end
            xs128_pkg::OP_BOOL:   o_entry.direct = {32'd0, n_buf[0]};
            default:              o_entry.direct = '0;
        endcase
    end

    assign o_wr_en = w_acc && !i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= xs128_pkg::INIT_Y;
            r_z <= xs128_pkg::INIT_Z;
            r_w <= xs128_pkg::INIT_W;
            r_buf <= '0;
            r_bits <= xs128_pkg::BITS_EMPTY;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_w <= n_w;
            r_buf <= n_buf;
            r_bits <= n_bits;
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_bits == xs128_pkg::BITS_EMPTY) && (r_y == xs128_pkg::INIT_Y)
            && (r_buf == '0))
        else $error("restart did not reload state");
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits != 6'd0) && (r_bits <= xs128_pkg::BITS_EMPTY))
        else $error("bit count out of range");

endmodule
`default_nettype wire

### hdl/xs128_back.sv
`timescale 1ns / 1ps
`default_nettype none
module xs128_back #(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_mid_empty,
    input  wire xs128_pkg::t_mid                i_mid,
    output logic                                o_mid_rd,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                o_out_wr,
    output logic [32:0]                         o_out_value
);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic                      r_s1_valid;
    xs128_pkg::t_kind          r_s1_kind;
    logic [32:0]               r_s1_direct;
    logic signed [31:0]        r_s1_lo;
    logic signed [64:0]        r_s1_prod;
    logic signed [64:0]        w_prod;
    logic signed [65:0]        w_num, w_bias, w_sum;
    logic [CW:0]               w_used;

    assign w_used   = (CW + 1)'(i_out_count) + (CW + 1)'(r_s1_valid);
    assign o_mid_rd = !i_mid_empty && (w_used < (CW + 1)'(OUT_DEPTH));
    assign w_prod   = 65'($signed({1'b0, i_mid.frac})) * 65'(i_mid.span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_mid_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_rd) begin
            r_s1_kind   <= i_mid.kind;
            r_s1_direct <= i_mid.direct;
            r_s1_lo     <= i_mid.lo;
            r_s1_prod   <= w_prod;
        end
    end

    // round toward zero: bias negative numerators before the shift
    assign w_num  = {{3{r_s1_lo[31]}}, r_s1_lo, 31'd0} + 66'(r_s1_prod);
    assign w_bias = w_num[65] ? 66'sh7FFF_FFFF : 66'sd0;
    assign w_sum  = w_num + w_bias;

    always_comb begin
        unique case (r_s1_kind)
            xs128_pkg::K_SCALE:  o_out_value = w_sum[63:31];
            default:             o_out_value = r_s1_direct;
        endcase
    end

    assign o_out_wr = r_s1_valid;

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_rd |-> (i_out_count < CW'(OUT_DEPTH)))
        else $error("accepted word without output room");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (i_out_count < CW'(OUT_DEPTH)))
        else $error("output queue overflow");

endmodule
`default_nettype wire
